### hw/rtl/richardson_iteration_solver_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Richardson iteration solver unit
// Concurrent checks, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef RICHARDSON_ITERATION_SOLVER_UNIT_MACROS_SVH
`define RICHARDSON_ITERATION_SOLVER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define RIS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("solver check failed");
// antecedent implies consequent in the next cycle
`define RIS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("solver check failed");
`else
`define RIS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define RIS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### hw/rtl/ris_pkg.sv
// ----------------------------------------------------------------------------
// ris_pkg
// Shared types and constants of the Richardson iteration solver.
// ----------------------------------------------------------------------------
`default_nettype none
package ris_pkg;
    localparam int DATA_W = 32;

    // write controls from the sequencer to the storage
    typedef struct packed {
        logic mat_we;
        logic rhs_we;
        logic x_we;
        logic x_bank;
    } store_ctl_t;
endpackage
`default_nettype wire

### hw/rtl/ris_store.sv
// ----------------------------------------------------------------------------
// ris_store
// Matrix memory and vector memory (right-hand side and two x banks).
// ----------------------------------------------------------------------------
`default_nettype none
module ris_store #(
    parameter int IDX_W = 6
) (
    input  wire logic                       clk,
    input  wire ris_pkg::store_ctl_t        ctl,
    input  wire logic [2*IDX_W-1:0]         mat_waddr,
    input  wire logic [2*IDX_W-1:0]         mat_raddr,
    input  wire logic [IDX_W-1:0]           vec_waddr,
    input  wire logic [IDX_W-1:0]           vec_raddr,
    input  wire logic [ris_pkg::DATA_W-1:0] wdata,
    output logic [ris_pkg::DATA_W-1:0]      mat_rdata,
    output logic [ris_pkg::DATA_W-1:0]      rhs_rdata,
    output logic [ris_pkg::DATA_W-1:0]      x0_rdata,
    output logic [ris_pkg::DATA_W-1:0]      x1_rdata
);
    import ris_pkg::*;

    localparam int MAT_DEPTH = 1 << (2 * IDX_W);
    localparam int VEC_DEPTH = 1 << IDX_W;

    logic [DATA_W-1:0]   mat_mem [MAT_DEPTH];
    // word: rhs, x bank 1, x bank 0
    logic [3*DATA_W-1:0] vec_mem [VEC_DEPTH];
    logic [3*DATA_W-1:0] vec_q;

    always_ff @(posedge clk)
    begin
        if (ctl.mat_we)
        begin
            mat_mem[mat_waddr] <= wdata;
        end
        mat_rdata <= mat_mem[mat_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rhs_we)
        begin
            vec_mem[vec_waddr][3*DATA_W-1:2*DATA_W] <= wdata;
        end
        if (ctl.x_we && ctl.x_bank)
        begin
            vec_mem[vec_waddr][2*DATA_W-1:DATA_W] <= wdata;
        end
        if (ctl.x_we && !ctl.x_bank)
        begin
            vec_mem[vec_waddr][DATA_W-1:0] <= wdata;
        end
        vec_q <= vec_mem[vec_raddr];
    end

    assign rhs_rdata = vec_q[3*DATA_W-1:2*DATA_W];
    assign x1_rdata  = vec_q[2*DATA_W-1:DATA_W];
    assign x0_rdata  = vec_q[DATA_W-1:0];
endmodule
`default_nettype wire

### hw/rtl/richardson_iteration_solver_unit.sv
// ----------------------------------------------------------------------------
// richardson_iteration_solver_unit
// Fixed-point Richardson solver for A*x = b with one shared multiplier.
// ----------------------------------------------------------------------------
// Use: load A and b one element per transfer on start (taken while busy is
// low, one transfer per cycle). A load with row, or A's col, >= MAX_SIZE is
// dropped. The transfer flagged last stores its element and starts a solve;
// busy stays high until the final result has been issued.
// Solve sequence, with n the active size: a norm pass over b, a threshold
// set-up (S_EPS, S_EPS2, S_THR), then per sweep two passes over n rows, each
// row n reads of the matrix memory through one multiplier, then the row
// close-out (S_DRAIN, S_FIN1 to S_FIN3), plus the test state S_TEST.
// The multiply and the one-word-per-cycle matrix read set the row length.
// Results: done strobes for one cycle per solution element, in index order;
// the receiver cannot stall, so take each transfer
// as it comes. converged and iterations hold the same value on every
// element; last_out marks the final one.
// Configuration: cfg_we writes register cfg_index; only while the unit is idle, a rule the user keeps.
// Reset: configuration and sequencer registers return to their defaults; the stores need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none
`include "richardson_iteration_solver_unit_macros.svh"
module richardson_iteration_solver_unit #(
    parameter int MAX_SIZE  = 64,
    parameter int FRAC_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        req_type,
    input  wire logic [5:0]  row,
    input  wire logic [5:0]  col,
    input  wire logic [31:0] value,
    input  wire logic        last,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_wdata,
    output logic             done,
    output logic [5:0]       index,
    output logic [31:0]      x_value,
    output logic             converged,
    output logic [15:0]      iterations,
    output logic             last_out
);
    import ris_pkg::*;

    localparam int IDX_W = $clog2(MAX_SIZE);
    localparam int RW    = (IDX_W > 6) ? IDX_W : 6;

    localparam logic [1:0] CFG_SIZE  = 2'd0;
    localparam logic [1:0] CFG_STEP  = 2'd1;
    localparam logic [1:0] CFG_TOL   = 2'd2;
    localparam logic [1:0] CFG_LIMIT = 2'd3;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ROW   = 4'd1;
    localparam logic [3:0] S_DRAIN = 4'd2;
    localparam logic [3:0] S_EPS   = 4'd3;
    localparam logic [3:0] S_EPS2  = 4'd4;
    localparam logic [3:0] S_THR   = 4'd5;
    localparam logic [3:0] S_FIN1  = 4'd6;
    localparam logic [3:0] S_FIN2  = 4'd7;
    localparam logic [3:0] S_FIN3  = 4'd8;
    localparam logic [3:0] S_TEST  = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;

    localparam logic [1:0] PASS_NORM = 2'd0;
    localparam logic [1:0] PASS_UPD  = 2'd1;
    localparam logic [1:0] PASS_RES  = 2'd2;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? {64{1'b1}} : s[63:0];
    endfunction

    // configuration registers
    logic [6:0]  msize_reg;
    logic [31:0] step_reg;
    logic [31:0] tol_reg;
    logic [15:0] maxit_reg;

    // control
    logic [3:0]       state_reg;
    logic [1:0]       pass_reg;
    logic [IDX_W-1:0] i_reg, j_reg, j1_reg, n_m1_reg, oidx_reg;
    logic             v1_reg, v2_reg;
    logic             first_reg, cur_reg, conv_reg;
    logic             done_reg, olast_reg;
    logic [15:0]      sweep_reg;
    logic [2:0]       thr_k_reg;

    // datapath
    logic signed [65:0]  prod_reg;
    logic signed [63:0]  acc_reg;
    logic [63:0]         norm_reg, res_reg, eps_reg;
    logic [127:0]        thr_reg;
    logic signed [31:0]  r_reg, bi_reg, xpi_reg;

    logic signed [32:0]  ma, mb;
    logic signed [65:0]  mprod;
    logic [31:0]         mat_rdata, rhs_rdata, x0_rdata, x1_rdata, x_rd;
    logic                rd_bank;
    logic signed [31:0]  v_rd;
    logic                accept, row_ok, col_ok;
    logic [RW-1:0]       row_w, col_w;
    logic [IDX_W-1:0]    row_idx, col_idx, n_m1_next, vec_waddr, vec_raddr;
    logic [31:0]         ms32;
    logic [15:0]         limit;
    logic signed [63:0]  prod_sh;
    logic signed [31:0]  x_new;
    logic [127:0]        thr_add;
    logic                conv_now;
    store_ctl_t          ctl;

    assign accept  = start && !busy;
    assign row_w   = RW'(row);
    assign col_w   = RW'(col);
    assign row_idx = row_w[IDX_W-1:0];
    assign col_idx = col_w[IDX_W-1:0];
    assign row_ok  = 32'(row) < MAX_SIZE;
    assign col_ok  = 32'(col) < MAX_SIZE;

    // clamp the active size into one to MAX_SIZE
    assign ms32 = 32'(msize_reg);
    always_comb
    begin
        if (ms32 == 32'd0)
            n_m1_next = '0;
        else if (ms32 > MAX_SIZE)
            n_m1_next = IDX_W'(MAX_SIZE - 1);
        else
            n_m1_next = IDX_W'(ms32 - 32'd1);
    end

    assign limit = (maxit_reg == 16'd0) ? 16'd1 : maxit_reg;

    // update pass reads the previous bank, residual pass and output the current one
    assign rd_bank = (pass_reg == PASS_UPD) ? !cur_reg : cur_reg;
    assign x_rd    = rd_bank ? x1_rdata : x0_rdata;
    assign v_rd    = (first_reg && pass_reg == PASS_UPD) ? 32'sd0 : $signed(x_rd);

    // shared multiplier operand selection
    always_comb
    begin
        ma = '0;
        mb = '0;
        case (state_reg)
            S_FIN2:
            begin
                ma = (pass_reg == PASS_UPD) ? 33'($signed(step_reg)) : 33'(r_reg);
                mb = 33'(r_reg);
            end
            S_EPS:
            begin
                ma = {1'b0, tol_reg};
                mb = {1'b0, tol_reg};
            end
            S_THR:
            begin
                ma = {1'b0, thr_k_reg[1] ? eps_reg[63:32] : eps_reg[31:0]};
                mb = {1'b0, thr_k_reg[0] ? norm_reg[63:32] : norm_reg[31:0]};
            end
            default:
            begin
                if (pass_reg == PASS_NORM)
                begin
                    ma = 33'($signed(rhs_rdata));
                    mb = 33'($signed(rhs_rdata));
                end
                else
                begin
                    ma = 33'($signed(mat_rdata));
                    mb = 33'(v_rd);
                end
            end
        endcase
    end
    assign mprod = ma * mb;

    assign prod_sh = $signed(prod_reg[63:0]) >>> FRAC_BITS;
    assign x_new   = sat32(64'(xpi_reg) - prod_sh);

    // partial product of the threshold, placed by its word offsets
    always_comb
    begin
        case (thr_k_reg)
            3'd1:    thr_add = {64'd0, prod_reg[63:0]};
            3'd2:    thr_add = {32'd0, prod_reg[63:0], 32'd0};
            3'd3:    thr_add = {32'd0, prod_reg[63:0], 32'd0};
            3'd4:    thr_add = {prod_reg[63:0], 64'd0};
            default: thr_add = '0;
        endcase
    end

    assign conv_now = (res_reg < thr_reg[127:64]) ||
                      (res_reg == thr_reg[127:64] && thr_reg[63:0] != 64'd0);

    // storage
    assign ctl.mat_we = accept && !req_type && row_ok && col_ok;
    assign ctl.rhs_we = accept && req_type && row_ok;
    assign ctl.x_we   = (state_reg == S_FIN3) && (pass_reg == PASS_UPD);
    assign ctl.x_bank = cur_reg;
    assign vec_waddr  = (state_reg == S_IDLE) ? row_idx : i_reg;
    assign vec_raddr  = (state_reg == S_OUT) ? i_reg : j_reg;

    ris_store #(
        .IDX_W(IDX_W)
    ) u_store (
        .clk      (clk),
        .ctl      (ctl),
        .mat_waddr({row_idx, col_idx}),
        .mat_raddr({i_reg, j_reg}),
        .vec_waddr(vec_waddr),
        .vec_raddr(vec_raddr),
        .wdata    ((state_reg == S_IDLE) ? value : x_new),
        .mat_rdata(mat_rdata),
        .rhs_rdata(rhs_rdata),
        .x0_rdata (x0_rdata),
        .x1_rdata (x1_rdata)
    );

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            msize_reg <= 7'd64;
            step_reg  <= 32'hFFFFFD71;
            tol_reg   <= 32'd429497;
            maxit_reg <= 16'd65535;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SIZE:  msize_reg <= cfg_wdata[6:0];
                CFG_STEP:  step_reg  <= cfg_wdata;
                CFG_TOL:   tol_reg   <= cfg_wdata;
                CFG_LIMIT: maxit_reg <= cfg_wdata[15:0];
                default:   msize_reg <= msize_reg;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        prod_reg <= mprod;
        if (v1_reg && j1_reg == i_reg)
        begin
            bi_reg  <= $signed(rhs_rdata);
            xpi_reg <= v_rd;
        end
        if (state_reg == S_FIN1)
            r_reg <= sat32(acc_reg - 64'(bi_reg));
        if (state_reg == S_EPS2)
            eps_reg <= prod_reg[63:0];
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pass_reg  <= PASS_NORM;
            i_reg     <= '0;
            j_reg     <= '0;
            j1_reg    <= '0;
            n_m1_reg  <= '0;
            oidx_reg  <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            first_reg <= 1'b1;
            cur_reg   <= 1'b0;
            conv_reg  <= 1'b0;
            done_reg  <= 1'b0;
            olast_reg <= 1'b0;
            sweep_reg <= '0;
            thr_k_reg <= '0;
            acc_reg   <= '0;
            norm_reg  <= '0;
            res_reg   <= '0;
            thr_reg   <= '0;
        end
        else
        begin
            // read pipeline: address, data, product
            v1_reg   <= (state_reg == S_ROW);
            j1_reg   <= j_reg;
            v2_reg   <= v1_reg;
            done_reg <= 1'b0;
            if (v2_reg)
            begin
                if (pass_reg == PASS_NORM)
                    norm_reg <= add_sat(norm_reg, prod_reg[63:0]);
                else
                    acc_reg <= acc_reg + prod_sh;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept && last)
                    begin
                        n_m1_reg  <= n_m1_next;
                        pass_reg  <= PASS_NORM;
                        i_reg     <= '0;
                        j_reg     <= '0;
                        acc_reg   <= '0;
                        norm_reg  <= '0;
                        first_reg <= 1'b1;
                        cur_reg   <= 1'b0;
                        sweep_reg <= '0;
                        state_reg <= S_ROW;
                    end
                end
                S_ROW:
                begin
                    if (j_reg == n_m1_reg)
                    begin
                        j_reg     <= '0;
                        state_reg <= S_DRAIN;
                    end
                    else
                    begin
                        j_reg <= j_reg + 1'b1;
                    end
                end
                S_DRAIN:
                begin
                    if (!v1_reg && !v2_reg)
                        state_reg <= (pass_reg == PASS_NORM) ? S_EPS : S_FIN1;
                end
                S_EPS:
                begin
                    state_reg <= S_EPS2;
                end
                S_EPS2:
                begin
                    thr_reg   <= '0;
                    thr_k_reg <= '0;
                    state_reg <= S_THR;
                end
                S_THR:
                begin
                    thr_reg   <= thr_reg + thr_add;
                    thr_k_reg <= thr_k_reg + 3'd1;
                    if (thr_k_reg == 3'd4)
                    begin
                        pass_reg  <= PASS_UPD;
                        state_reg <= S_ROW;
                    end
                end
                S_FIN1:
                begin
                    acc_reg   <= '0;
                    state_reg <= S_FIN2;
                end
                S_FIN2:
                begin
                    state_reg <= S_FIN3;
                end
                S_FIN3:
                begin
                    if (pass_reg == PASS_RES)
                        res_reg <= add_sat(res_reg, prod_reg[63:0]);
                    if (i_reg == n_m1_reg)
                    begin
                        i_reg <= '0;
                        if (pass_reg == PASS_UPD)
                        begin
                            sweep_reg <= sweep_reg + 16'd1;
                            res_reg   <= '0;
                            pass_reg  <= PASS_RES;
                            state_reg <= S_ROW;
                        end
                        else
                        begin
                            state_reg <= S_TEST;
                        end
                    end
                    else
                    begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= S_ROW;
                    end
                end
                S_TEST:
                begin
                    if (conv_now || sweep_reg >= limit)
                    begin
                        conv_reg  <= conv_now;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        // new previous iterate is the current bank
                        cur_reg   <= !cur_reg;
                        first_reg <= 1'b0;
                        pass_reg  <= PASS_UPD;
                        state_reg <= S_ROW;
                    end
                end
                S_OUT:
                begin
                    done_reg  <= 1'b1;
                    oidx_reg  <= i_reg;
                    olast_reg <= (i_reg == n_m1_reg);
                    if (i_reg == n_m1_reg)
                    begin
                        i_reg     <= '0;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        i_reg <= i_reg + 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign index      = 6'(oidx_reg);
    assign x_value    = cur_reg ? x1_rdata : x0_rdata;
    assign converged  = conv_reg;
    assign iterations = sweep_reg;
    assign last_out   = olast_reg;

    `RIS_ASSERT_IMP(a_done_from_out, clk, rst_n, done, $past(state_reg) == S_OUT)
    `RIS_ASSERT_NEXT(a_last_starts, clk, rst_n, start && !busy && last, state_reg == S_ROW)
    `RIS_ASSERT_IMP(a_x_write, clk, rst_n, ctl.x_we, !ctl.mat_we && !ctl.rhs_we)
    `RIS_ASSERT_IMP(a_sweep_bound, clk, rst_n, state_reg == S_TEST, sweep_reg <= limit)
endmodule
`default_nettype wire
